// ----- sv/wtp_pkg.sv -----
// Package for the weighted task picker.
// Holds the slot record, the transaction kind codes and the status codes.
// Has no dependencies.
package wtp_pkg;

  localparam logic [15:0] RUNS_UNLIMITED = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_PICK     = 2'd2,
    KIND_COMPLETE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_NONE    = 2'd2,
    STATUS_UNKNOWN = 2'd3
  } status_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [15:0] runs_left;
    logic [7:0]  par_limit;
    logic [7:0]  run_count;
    logic [31:0] last_finish;
    logic [31:0] last_dur;
  } slot_t;

endpackage

// ----- sv/wtp_cell.sv -----
// One task slot of the rotating slot ring.
// Loads its neighbor's slot whenever the ring shifts. Depends on wtp_pkg.
module wtp_cell
  import wtp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  slot_t slot_i,
  output slot_t slot_o
);

  logic  valid_q;
  slot_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= slot_i;
    end
  end

  always_comb begin
    slot_o       = data_q;
    slot_o.valid = valid_q;
  end

endmodule

// ----- sv/weighted_task_picker.sv -----
// Top level of the weighted task picker: a ring of task slot cells and its sequencer.
// Depends on wtp_pkg and wtp_cell.
//
// The task slots form a ring of cells that rotates one place per shift, and every
// transaction runs two full turns of that ring: a search turn, in which each slot
// passes through the registered cross-multiplier before its compare, and an update
// turn that writes the changed slot back. The block takes no new transaction until
// the current one has handed its result to the output register, but a new one is
// accepted while the previous result still waits at the output.
module weighted_task_picker
  import wtp_pkg::*;
#(
  parameter int TASK_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] now_i,
  input  logic [31:0] start_time_i,
  input  logic [31:0] task_ref_i,
  input  logic [15:0] runs_allowed_i,
  input  logic [7:0]  max_parallel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] task_id_o
);

  localparam int IdxW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TASK_SLOTS - 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSearch = 3'd1;
  localparam logic [2:0] StDecide = 3'd2;
  localparam logic [2:0] StApply  = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  logic [2:0] state_q, state_d;

  kind_e       kind_q;
  logic [31:0] now_q, start_q, ref_q;
  logic [15:0] runs_q;
  logic [7:0]  par_q;
  logic [31:0] next_id_q;

  logic [IdxW-1:0] k_q;
  logic            ph_q;

  logic            elig_q;
  logic [31:0]     idle_q;
  logic [63:0]     lhs_q, rhs_q;
  logic            best_found_q, match_found_q, free_found_q;
  logic [IdxW-1:0] best_idx_q, match_idx_q, free_idx_q;
  logic [31:0]     bidle_q, bdur_q, bid_q;

  logic            apply_q, apply_d;
  logic [IdxW-1:0] tgt_q, tgt_d;
  status_e         res_status_q, res_status_d;
  logic [31:0]     res_id_q, res_id_d;

  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [31:0] out_id_q;

  slot_t ring [TASK_SLOTS];
  slot_t head, tail_d, mod_slot;
  logic  shift;

  assign head = ring[0];

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    slot_t cell_in;
    if (i == TASK_SLOTS - 1) begin : g_tail
      assign cell_in = tail_d;
    end else begin : g_mid
      assign cell_in = ring[i+1];
    end
    wtp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .slot_i (cell_in),
      .slot_o (ring[i])
    );
  end

  logic [31:0] key, head_idle, comp_dur;
  logic        head_elig, out_free;

  assign key       = (kind_q == KIND_ADD) ? next_id_q : ref_q;
  assign head_idle = now_q - head.last_finish;
  assign head_elig = head.valid && (head.run_count < head.par_limit) &&
                     (head.runs_left != 16'd0) && (head.last_dur != 32'd0);
  assign comp_dur  = now_q - start_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign shift = ((state_q == StSearch) && ph_q) || (state_q == StApply);

  always_comb begin
    mod_slot = head;
    unique case (kind_q)
      KIND_ADD: begin
        mod_slot.valid       = 1'b1;
        mod_slot.id          = res_id_q;
        mod_slot.runs_left   = runs_q;
        mod_slot.par_limit   = par_q;
        mod_slot.run_count   = 8'd0;
        mod_slot.last_finish = now_q;
        mod_slot.last_dur    = 32'd1;
      end
      KIND_REMOVE: begin
        mod_slot.valid = 1'b0;
      end
      KIND_PICK: begin
        mod_slot.run_count = head.run_count + 8'd1;
        if (head.runs_left != RUNS_UNLIMITED) begin
          mod_slot.runs_left = head.runs_left - 16'd1;
        end
      end
      KIND_COMPLETE: begin
        if (head.run_count != 8'd0) begin
          mod_slot.run_count = head.run_count - 8'd1;
        end
        mod_slot.last_finish = now_q;
        mod_slot.last_dur    = (comp_dur != 32'd0) ? comp_dur : 32'd1;
      end
      default: mod_slot = head;
    endcase
  end

  assign tail_d = ((state_q == StApply) && apply_q && (k_q == tgt_q)) ? mod_slot : head;

  always_comb begin
    apply_d      = 1'b0;
    tgt_d        = match_idx_q;
    res_status_d = STATUS_OK;
    res_id_d     = ref_q;
    unique case (kind_q)
      KIND_ADD: begin
        res_id_d = next_id_q;
        if (match_found_q) begin
          apply_d = 1'b1;
        end else if (free_found_q) begin
          apply_d = 1'b1;
          tgt_d   = free_idx_q;
        end else begin
          res_status_d = STATUS_FULL;
          res_id_d     = 32'd0;
        end
      end
      KIND_PICK: begin
        if (best_found_q) begin
          apply_d  = 1'b1;
          tgt_d    = best_idx_q;
          res_id_d = bid_q;
        end else begin
          res_status_d = STATUS_NONE;
          res_id_d     = 32'd0;
        end
      end
      KIND_REMOVE, KIND_COMPLETE: begin
        if (match_found_q) begin
          apply_d = 1'b1;
        end else begin
          res_status_d = STATUS_UNKNOWN;
        end
      end
      default: apply_d = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StSearch;
      StSearch: if (ph_q && (k_q == LastIdx)) state_d = StDecide;
      StDecide: state_d = StApply;
      StApply:  if (k_q == LastIdx) state_d = StDone;
      StDone:   if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      next_id_q   <= 32'd0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      ph_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle) begin
        k_q  <= '0;
        ph_q <= 1'b0;
      end else if (state_q == StSearch) begin
        ph_q <= !ph_q;
        if (ph_q) begin
          k_q <= (k_q == LastIdx) ? '0 : k_q + IdxW'(1);
        end
      end else if (state_q == StApply) begin
        k_q <= (k_q == LastIdx) ? '0 : k_q + IdxW'(1);
      end
      if ((state_q == StDecide) && (kind_q == KIND_ADD) &&
          (match_found_q || free_found_q)) begin
        next_id_q <= next_id_q + 32'd1;
      end
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StIdle) && in_valid_i) begin
      kind_q        <= kind_e'(kind_i);
      now_q         <= now_i;
      start_q       <= start_time_i;
      ref_q         <= task_ref_i;
      runs_q        <= runs_allowed_i;
      par_q         <= max_parallel_i;
      best_found_q  <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
    end
    if ((state_q == StSearch) && !ph_q) begin
      elig_q <= head_elig;
      idle_q <= head_idle;
      lhs_q  <= 64'(head_idle) * 64'(bdur_q);
      rhs_q  <= 64'(bidle_q) * 64'(head.last_dur);
    end
    if ((state_q == StSearch) && ph_q) begin
      if (elig_q && (!best_found_q || (lhs_q < rhs_q) ||
                     ((lhs_q == rhs_q) && (head.id < bid_q)))) begin
        best_found_q <= 1'b1;
        best_idx_q   <= k_q;
        bidle_q      <= idle_q;
        bdur_q       <= head.last_dur;
        bid_q        <= head.id;
      end
      if (head.valid && (head.id == key) && !match_found_q) begin
        match_found_q <= 1'b1;
        match_idx_q   <= k_q;
      end
      if (!head.valid && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= k_q;
      end
    end
    if (state_q == StDecide) begin
      apply_q      <= apply_d;
      tgt_q        <= tgt_d;
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
    end
    if ((state_q == StDone) && out_free) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign task_id_o   = out_id_q;

endmodule

// ----- tb/weighted_task_picker_tb.sv -----
// Self-checking testbench for the weighted task picker.
// Drives add, remove, pick and completion transactions, predicts each result with a
// model of the slot table, and depends on wtp_pkg and weighted_task_picker.
module weighted_task_picker_tb;
  import wtp_pkg::*;

  localparam int SLOTS = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now;
    logic [31:0] start;
    logic [31:0] ref_id;
    logic [15:0] runs;
    logic [7:0]  par;
    logic        chk;
    logic [1:0]  st;
    logic [31:0] tid;
  } row_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] tid;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic [31:0] now_i = '0;
  logic [31:0] start_time_i = '0;
  logic [31:0] task_ref_i = '0;
  logic [15:0] runs_allowed_i = '0;
  logic [7:0]  max_parallel_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] task_id_o;

  slot_t       table_q [SLOTS];
  logic [31:0] id_next;
  answer_t     answers_q[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic [31:0] clock_ms = 32'd1000;

  weighted_task_picker #(.TASK_SLOTS(SLOTS)) dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic int lookup(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (table_q[i].valid && table_q[i].id == id) return i;
    return -1;
  endfunction

  function automatic answer_t schedule(row_t r);
    answer_t     a;
    int          s;
    int          best;
    logic [63:0] lhs, rhs, idle, bidle, bdur, dur;
    a = '0;
    best = -1;
    bidle = '0;
    bdur = '0;
    case (kind_e'(r.kind))
      KIND_ADD: begin
        s = lookup(id_next);
        for (int i = 0; i < SLOTS && s < 0; i++)
          if (!table_q[i].valid) s = i;
        if (s < 0) begin
          a.st = STATUS_FULL;
        end else begin
          table_q[s] = '{1'b1, id_next, r.runs, r.par, 8'd0, r.now, 32'd1};
          a.tid = id_next;
          id_next = id_next + 32'd1;
        end
      end
      KIND_REMOVE: begin
        s = lookup(r.ref_id);
        a.tid = r.ref_id;
        if (s < 0) a.st = STATUS_UNKNOWN;
        else table_q[s].valid = 1'b0;
      end
      KIND_PICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!table_q[i].valid || table_q[i].run_count >= table_q[i].par_limit ||
              table_q[i].runs_left == 0 || table_q[i].last_dur == 0) continue;
          idle = {32'd0, r.now - table_q[i].last_finish};
          dur = {32'd0, table_q[i].last_dur};
          if (best >= 0) begin
            lhs = idle * bdur;
            rhs = bidle * dur;
            if (!(lhs < rhs || (lhs == rhs && table_q[i].id < table_q[best].id))) continue;
          end
          best = i;
          bidle = idle;
          bdur = dur;
        end
        if (best < 0) begin
          a.st = STATUS_NONE;
        end else begin
          table_q[best].run_count++;
          if (table_q[best].runs_left != RUNS_UNLIMITED) table_q[best].runs_left--;
          a.tid = table_q[best].id;
        end
      end
      default: begin
        s = lookup(r.ref_id);
        a.tid = r.ref_id;
        if (s < 0) begin
          a.st = STATUS_UNKNOWN;
        end else begin
          if (table_q[s].run_count > 0) table_q[s].run_count--;
          table_q[s].last_finish = r.now;
          table_q[s].last_dur = (r.now - r.start) == 0 ? 32'd1 : r.now - r.start;
        end
      end
    endcase
    return a;
  endfunction

  task automatic send(row_t r);
    answer_t a;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    kind_i <= r.kind;
    now_i <= r.now;
    start_time_i <= r.start;
    task_ref_i <= r.ref_id;
    runs_allowed_i <= r.runs;
    max_parallel_i <= r.par;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    a = schedule(r);
    if (r.chk && a != {r.st, r.tid}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row predicted %0d/%h, typed %0d/%h", a.st, a.tid, r.st, r.tid);
    end
    answers_q = {answers_q, a};
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answers_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%h", status_o, task_id_o);
      end else begin
        want = answers_q.pop_front();
        if (status_o !== want.st || task_id_o !== want.tid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d/%h, got %0d/%h",
                     want.st, want.tid, status_o, task_id_o);
        end
      end
    end
  end

  function automatic row_t mk(kind_e k, logic [31:0] now, logic [31:0] st,
                              logic [31:0] rf, logic [15:0] ru, logic [7:0] pa);
    return '{k, now, st, rf, ru, pa, 1'b0, 2'd0, 32'd0};
  endfunction

  function automatic row_t typed(row_t r, status_e s, logic [31:0] t);
    r.chk = 1'b1;
    r.st = s;
    r.tid = t;
    return r;
  endfunction

  function automatic logic [31:0] known_id();
    int n;
    n = $urandom_range(SLOTS - 1);
    if (table_q[n].valid && $urandom_range(9) < 8) return table_q[n].id;
    return $urandom_range(3) == 0 ? $urandom : id_next - 32'($urandom_range(20));
  endfunction

  function automatic row_t random_row();
    row_t r;
    int   p;
    p = $urandom_range(99);
    clock_ms = clock_ms + 32'($urandom_range(50));
    r = mk(KIND_PICK, clock_ms, clock_ms - 32'($urandom_range(40)), known_id(),
           16'($urandom_range(6)), 8'($urandom_range(3)));
    if (p < 22) begin
      r.kind = KIND_ADD;
      if ($urandom_range(9) == 0) r.runs = 16'($urandom);
      if ($urandom_range(9) == 0) r.runs = RUNS_UNLIMITED;
      if ($urandom_range(9) == 0) r.par = 8'($urandom);
    end else if (p < 32) r.kind = KIND_REMOVE;
    else if (p < 65) r.kind = KIND_PICK;
    else r.kind = KIND_COMPLETE;
    if ($urandom_range(19) == 0) begin
      r.now = $urandom;
      r.start = $urandom;
      r.ref_id = $urandom;
    end
    if ($urandom_range(29) == 0) r.start = r.now;
    return r;
  endfunction

  row_t directed[$];
  initial begin
    int ph;
    for (int i = 0; i < SLOTS; i++) table_q[i] = '0;
    id_next = '0;
    directed = '{
      typed(mk(KIND_PICK, 0, 0, 0, 0, 0), STATUS_NONE, 0),
      typed(mk(KIND_REMOVE, 0, 0, 32'hFFFFFFFF, 0, 0), STATUS_UNKNOWN, 32'hFFFFFFFF),
      typed(mk(KIND_COMPLETE, 5, 0, 7, 0, 0), STATUS_UNKNOWN, 7),
      typed(mk(KIND_ADD, 32'hFFFFFFF0, 0, 0, RUNS_UNLIMITED, 8'hFF), STATUS_OK, 0),
      typed(mk(KIND_ADD, 100, 0, 0, 16'd2, 8'd1), STATUS_OK, 1),
      typed(mk(KIND_ADD, 100, 0, 0, 16'd0, 8'd1), STATUS_OK, 2),
      typed(mk(KIND_ADD, 100, 0, 0, 16'd1, 8'd0), STATUS_OK, 3),
      mk(KIND_PICK, 32'h00000020, 0, 0, 0, 0),
      mk(KIND_PICK, 32'h00000030, 0, 0, 0, 0),
      mk(KIND_PICK, 32'h00000040, 0, 0, 0, 0),
      mk(KIND_COMPLETE, 200, 200, 1, 0, 0),
      mk(KIND_COMPLETE, 200, 32'hFFFFFFFF, 0, 0, 0),
      mk(KIND_COMPLETE, 300, 100, 1, 0, 0),
      mk(KIND_PICK, 400, 0, 0, 0, 0),
      mk(KIND_PICK, 32'hFFFFFFFF, 0, 0, 0, 0),
      typed(mk(KIND_REMOVE, 0, 0, 2, 0, 0), STATUS_OK, 2),
      typed(mk(KIND_REMOVE, 0, 0, 2, 0, 0), STATUS_UNKNOWN, 2)
    };
    for (int i = 0; i < 14; i++)
      directed = {directed, mk(KIND_ADD, 32'h55AA55AA, 0, 0, 16'hAAAA, 8'h55)};
    directed = {directed, typed(mk(KIND_ADD, 0, 0, 0, 16'h5555, 8'hAA), STATUS_FULL, 0)};
    directed = {directed, mk(KIND_PICK, 32'hAA55AA55, 0, 0, 0, 0)};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send(directed[i]);
    for (int i = 0; i < SLOTS; i++)
      if (table_q[i].valid) send(mk(KIND_REMOVE, 0, 0, table_q[i].id, 0, 0));
    for (int n = 0; n < 450; n++) begin
      ph = n / 113;
      send_idle_pct = (ph == 1) ? 66 : (ph == 3 ? 30 : 0);
      stall_pct = (ph == 2) ? 66 : (ph == 3 ? 30 : 0);
      send(random_row());
    end
    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (mismatches == 0) $display("weighted_task_picker regression: pass");
    else $display("weighted_task_picker regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("weighted_task_picker regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/wtp_pkg.sv
sv/wtp_cell.sv
sv/weighted_task_picker.sv
tb/weighted_task_picker_tb.sv
